### hdl/ibf_pkg.sv
package ibf_pkg;
    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [11:0] POS_MAX        = 12'd4095;

    typedef struct packed {
        logic scan_start;  // begin a sweep of the table
        logic is_insert;
        logic is_remove;
        logic is_lookup;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       free_found;
        logic       clear_done;
    } t_status;
endpackage

### hdl/ipv4_source_blacklist_filter.sv
// IPv4 source blacklist filter. Frame bytes (cmd 0) are taken one per cycle
// while no transaction is pending; the last byte of a frame that passes parsing,
// and each insert or remove command, start a sweep of the TABLE_DEPTH-entry key
// RAM at one entry per cycle, set by the single RAM read port. Frames that fail
// parsing skip the sweep. After reset a clearing pass over all TABLE_DEPTH
// entries runs before the first transaction.
module ipv4_source_blacklist_filter
    import ibf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // data_byte[7:0], table_address[39:8], zero
    input  logic [1:0]   s_axis_tuser,  // cmd
    input  logic         s_axis_tlast,  // frame_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // drop, event, src, dst, sport, dport,
                                        // proto, status, zero
    output logic         m_axis_tuser   // is_table_reply
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    t_cmd    tcmd;
    t_status tst;
    logic take, cap, ev, drop;
    logic [1:0] tstat;
    logic [31:0] src, dst, r_src, r_dst, r_key;
    logic [15:0] sp, dp, r_sp, r_dp;
    logic [7:0]  pr, r_pr;
    logic r_ev, r_reply;

    ibf_parser u_parser (.i_clk, .i_rst_n, .i_take(take), .i_byte(s_axis_tdata[7:0]),
        .i_last(s_axis_tlast), .o_event(ev), .o_src(src), .o_dst(dst),
        .o_sport(sp), .o_dport(dp), .o_proto(pr));

    ibf_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .i_cmd(s_axis_tuser),
        .i_last(s_axis_tlast), .i_event(ev), .i_out_ready(m_axis_tready),
        .i_status(tst), .o_ready(s_axis_tready), .o_take(take), .o_capture(cap),
        .o_tcmd(tcmd), .o_out_valid(m_axis_tvalid), .o_tstatus(tstat), .o_drop(drop));

    ibf_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (.i_clk, .i_rst_n,
        .i_cmd(tcmd), .i_key(r_key), .o_status(tst));

    // hold the result fields of the captured transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0; r_reply <= 1'b0;
        end else if (cap) begin
            r_reply <= s_axis_tuser != CMD_BYTE;
            r_ev    <= s_axis_tuser == CMD_BYTE && ev;
        end
    end
    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_key <= (s_axis_tuser == CMD_BYTE) ? src : s_axis_tdata[39:8];
            r_src <= src; r_dst <= dst; r_sp <= sp; r_dp <= dp; r_pr <= pr;
        end
    end

    assign m_axis_tuser = r_reply;
    assign m_axis_tdata = {4'd0, (r_reply ? tstat : 2'd0),
        (r_ev ? {r_pr, r_dp, r_sp, r_dst, r_src, 1'b1, drop} : 106'd0)};
endmodule

### hdl/ibf_table.sv
module ibf_table
    import ibf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_key,
    output t_status     o_status
);
    // Keys in a RAM, valid bits in a RAM cleared by a sweep after reset.
    logic [31:0] r_keys  [DEPTH];
    logic        r_valid [DEPTH];
    logic [AW:0] r_idx;
    logic [AW:0] r_rd;      // index of the registered read
    logic        r_rd_on;
    logic        r_busy;
    logic        r_clr;
    logic [31:0] r_key_q;
    logic        r_val_q;
    logic        r_hit, r_free;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic        r_done;
    logic        r_ins, r_rem;

    always_ff @(posedge i_clk) begin
        if (r_rd_on) begin
            r_key_q <= r_keys[r_rd[AW-1:0]];
            r_val_q <= r_valid[r_rd[AW-1:0]];
        end
        if (r_clr) r_valid[r_idx[AW-1:0]] <= 1'b0;
        else if (r_done && r_ins && !r_hit && r_free) begin
            r_keys[r_free_idx]  <= i_key;
            r_valid[r_free_idx] <= 1'b1;
        end else if (r_done && r_rem && r_hit)
            r_valid[r_hit_idx] <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_idx <= '0; r_busy <= 1'b0; r_rd_on <= 1'b0;
            r_done <= 1'b0; r_hit <= 1'b0; r_free <= 1'b0; r_rd <= '0;
            r_ins <= 1'b0; r_rem <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_clr) begin
                if (r_idx == (AW+1)'(DEPTH - 1)) r_clr <= 1'b0;
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.scan_start && !r_busy && !r_done) begin
                // start once per request; the done cycle still sees the request
                r_busy <= 1'b1; r_rd <= '0; r_rd_on <= 1'b1; r_idx <= '0;
                r_hit <= 1'b0; r_free <= 1'b0;
                r_ins <= i_cmd.is_insert; r_rem <= i_cmd.is_remove;
            end else if (r_busy) begin
                // advance read pointer; evaluate the entry read last cycle
                if (r_rd == (AW+1)'(DEPTH - 1)) r_rd_on <= 1'b0;
                else r_rd <= r_rd + 1'b1;
                if (r_idx != r_rd || !r_rd_on) begin
                    if (r_val_q && r_key_q == i_key && !r_hit) begin
                        r_hit <= 1'b1; r_hit_idx <= r_idx[AW-1:0];
                    end
                    if (!r_val_q && !r_free) begin
                        r_free <= 1'b1; r_free_idx <= r_idx[AW-1:0];
                    end
                    if (r_idx == (AW+1)'(DEPTH - 1)) begin
                        r_busy <= 1'b0; r_done <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_status = '{scan_done: r_done, hit: r_hit, free_found: r_free,
                        clear_done: !r_clr};
endmodule

### hdl/ibf_parser.sv
module ibf_parser
    import ibf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_event,
    output logic [31:0] o_src,
    output logic [31:0] o_dst,
    output logic [15:0] o_sport,
    output logic [15:0] o_dport,
    output logic [7:0]  o_proto
);
    logic [11:0] r_pos;
    logic [15:0] r_eth;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [31:0] r_src, r_dst;
    logic [15:0] r_sp, r_dp;
    logic [12:0] toff, len;
    logic [7:0]  n_proto;
    logic [3:0]  n_ihl;
    logic [15:0] n_eth;
    logic [31:0] n_src, n_dst;
    logic [15:0] n_sp, n_dp;

    // fields updated by the current byte, so the verdict sees them
    always_comb begin
        toff = 13'd14 + {7'd0, r_ihl, 2'b00};
        n_eth = r_eth; n_ihl = r_ihl; n_proto = r_proto;
        n_src = r_src; n_dst = r_dst; n_sp = r_sp; n_dp = r_dp;
        if (r_pos == 12'd12 || r_pos == 12'd13) n_eth = {r_eth[7:0], i_byte};
        if (r_pos == 12'd14) n_ihl = i_byte[3:0];
        if (r_pos == 12'd23) n_proto = i_byte;
        if (r_pos >= 12'd26 && r_pos <= 12'd29) n_src = {r_src[23:0], i_byte};
        if (r_pos >= 12'd30 && r_pos <= 12'd33) n_dst = {r_dst[23:0], i_byte};
        if (r_pos > 12'd14 && {1'b0, r_pos} >= toff && {1'b0, r_pos} < toff + 13'd2)
            n_sp = {r_sp[7:0], i_byte};
        if (r_pos > 12'd14 && {1'b0, r_pos} >= toff + 13'd2
            && {1'b0, r_pos} < toff + 13'd4)
            n_dp = {r_dp[7:0], i_byte};
        len = (r_pos == POS_MAX) ? {1'b0, r_pos} : {1'b0, r_pos} + 13'd1;
        o_event = len >= 13'd34 && n_eth == ETHERTYPE_IPV4 && r_ihl >= 4'd5;
        if (r_proto == PROTO_TCP && len < toff + 13'd20) o_event = 1'b0;
        if (r_proto == PROTO_UDP && len < toff + 13'd8)  o_event = 1'b0;
        o_src = n_src; o_dst = n_dst; o_proto = n_proto;
        o_sport = (n_proto == PROTO_TCP || n_proto == PROTO_UDP) ? n_sp : 16'd0;
        o_dport = (n_proto == PROTO_TCP || n_proto == PROTO_UDP) ? n_dp : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos <= '0; r_eth <= '0; r_ihl <= '0; r_proto <= '0;
            r_src <= '0; r_dst <= '0; r_sp <= '0; r_dp <= '0;
        end else if (i_take) begin
            if (r_pos != POS_MAX) r_pos <= r_pos + 12'd1;
            r_eth <= n_eth; r_ihl <= n_ihl; r_proto <= n_proto;
            r_src <= n_src; r_dst <= n_dst; r_sp <= n_sp; r_dp <= n_dp;
        end
    end
endmodule

### hdl/ibf_ctrl.sv
module ibf_ctrl
    import ibf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [1:0] i_cmd,
    input  logic    i_last,
    input  logic    i_event,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_take,
    output logic    o_capture,
    output t_cmd    o_tcmd,
    output logic    o_out_valid,
    output logic [1:0] o_tstatus,
    output logic    o_drop
);
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_OUT = 2'd2;
    logic [1:0] r_state, n_state;
    logic       r_ins, r_rem, r_look;
    logic       acc;

    assign o_ready = (r_state == S_IDLE) && i_status.clear_done;
    assign acc = i_valid && o_ready;
    assign o_take = acc && i_cmd == CMD_BYTE;
    assign o_capture = acc && (i_cmd == CMD_INSERT || i_cmd == CMD_REMOVE
                               || (i_cmd == CMD_BYTE && i_last));
    assign o_out_valid = r_state == S_OUT;
    assign o_tcmd = '{scan_start: r_state == S_SCAN, is_insert: r_ins,
                      is_remove: r_rem, is_lookup: r_look};

    // sequence: capture, sweep the table when needed, then present result
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (o_capture)
                n_state = (i_cmd != CMD_BYTE || i_event) ? S_SCAN : S_OUT;
            S_SCAN: if (i_status.scan_done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ins <= 1'b0; r_rem <= 1'b0; r_look <= 1'b0;
            o_tstatus <= ST_OK; o_drop <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_capture) begin
                r_ins <= i_cmd == CMD_INSERT; r_rem <= i_cmd == CMD_REMOVE;
                r_look <= i_cmd == CMD_BYTE;
                o_tstatus <= ST_OK; o_drop <= 1'b0;
            end
            if (r_state == S_SCAN && i_status.scan_done) begin
                if (r_look) o_drop <= i_status.hit;
                if (r_ins && !i_status.hit && !i_status.free_found) o_tstatus <= ST_FULL;
                if (r_rem && !i_status.hit) o_tstatus <= ST_NOTFOUND;
            end
        end
    end
endmodule

### hdl/ibf_checker.sv
module ibf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result pending");
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[105:0] == 106'd0)
        else $error("table reply carries event fields");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("drop without event");
endmodule

bind ipv4_source_blacklist_filter ibf_checker u_ibf_checker (.*);

### dv/tb_ipv4_source_blacklist_filter.sv
`timescale 1ns / 1ps

module tb_ipv4_source_blacklist_filter;
    import ibf_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 4000;
    localparam int TAIL_WAIT  = DEPTH + 64;
    localparam int ITEM_GOAL  = 1800;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // data_byte, table_address, zero
    logic [1:0]   s_axis_tuser;   // cmd
    logic         s_axis_tlast;   // frame_end
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // drop, event, src, dst, sport, dport, proto, status, zero
    logic         m_axis_tuser;   // is_table_reply

    ipv4_source_blacklist_filter #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    typedef struct packed {
        logic        reply;
        logic        drop;
        logic        evt;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [1:0]  status;
    } t_verdict;

    // Parse state and blacklist mirror, plus the queue of pending verdicts
    class filter_scoreboard;
        int unsigned pos;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src, dst;
        logic [15:0] sport, dport;
        logic [31:0] keys [DEPTH];
        bit          used [DEPTH];
        t_verdict    pending [$];
        int          errors;

        function void clear_parse();
            pos = 0; etype = '0; ihl = '0; proto = '0;
            src = '0; dst = '0; sport = '0; dport = '0;
        endfunction

        function int lookup(logic [31:0] key);
            for (int i = 0; i < DEPTH; i++)
                if (used[i] && keys[i] == key) return i;
            return -1;
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] b, logic last,
                                 logic [31:0] addr);
            t_verdict v;
            int k, free_slot, toff;
            bit evt;
            v = '0;
            free_slot = -1;
            // Table commands answer at once and leave the frame parse alone
            if (cmd == CMD_INSERT || cmd == CMD_REMOVE) begin
                v.reply = 1'b1;
                k = lookup(addr);
                if (cmd == CMD_INSERT) begin
                    if (k < 0) begin
                        for (int i = 0; i < DEPTH && free_slot < 0; i++)
                            if (!used[i]) free_slot = i;
                        if (free_slot < 0) v.status = ST_FULL;
                        else begin
                            keys[free_slot] = addr;
                            used[free_slot] = 1'b1;
                        end
                    end
                end else if (k < 0) begin
                    v.status = ST_NOTFOUND;
                end else begin
                    used[k] = 1'b0;
                end
                pending.push_back(v);
                return;
            end
            if (cmd != CMD_BYTE) return;
            // Capture header fields by byte position
            toff = 14 + 4 * ihl;
            if (pos == 12 || pos == 13) etype = {etype[7:0], b};
            if (pos == 14) ihl = b[3:0];
            if (pos == 23) proto = b;
            if (pos >= 26 && pos <= 29) src = {src[23:0], b};
            if (pos >= 30 && pos <= 33) dst = {dst[23:0], b};
            if (pos > 14 && pos >= toff && pos < toff + 2) sport = {sport[7:0], b};
            if (pos > 14 && pos >= toff + 2 && pos < toff + 4) dport = {dport[7:0], b};
            if (pos < POS_MAX) pos++;
            if (!last) return;
            // Verdict on the last byte
            evt = 1'b0;
            if (pos >= 34 && etype == ETHERTYPE_IPV4 && ihl >= 5) begin
                evt = 1'b1;
                if (proto == PROTO_TCP) begin
                    if (pos < toff + 20) evt = 1'b0;
                    v.sport = sport; v.dport = dport;
                end else if (proto == PROTO_UDP) begin
                    if (pos < toff + 8) evt = 1'b0;
                    v.sport = sport; v.dport = dport;
                end
            end
            if (evt) begin
                v.drop  = lookup(src) >= 0;
                v.evt   = 1'b1;
                v.src   = src;
                v.dst   = dst;
                v.proto = proto;
            end else begin
                v.sport = '0; v.dport = '0;
            end
            pending.push_back(v);
            clear_parse();
        endfunction

        function void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [111:0] d, logic user);
            t_verdict e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h/%h",
                         $time, user, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            report("is_table_reply", 32'(e.reply), 32'(user));
            report("drop_frame", 32'(e.drop), 32'(d[0]));
            report("event_valid", 32'(e.evt), 32'(d[1]));
            report("source_address", e.src, d[33:2]);
            report("dest_address", e.dst, d[65:34]);
            report("source_port", 32'(e.sport), 32'(d[81:66]));
            report("dest_port", 32'(e.dport), 32'(d[97:82]));
            report("ip_protocol", 32'(e.proto), 32'(d[105:98]));
            report("table_status", 32'(e.status), 32'(d[107:106]));
            report("padding", 32'd0, 32'(d[111:108]));
        endfunction
    endclass

    filter_scoreboard board;
    logic [31:0] hot_addrs [8];
    int  items_sent;
    bit  send_bursty;
    bit  hold_req;
    bit  hold_done;
    int  idle_cycles;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** ipv4_source_blacklist_filter: FAILED **");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stalls, quiet stretches, one long hold-off on request
    initial begin
        int gap;
        bit quiet;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 40) == 0) quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 18);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_LEN;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send(logic [1:0] cmd, logic [7:0] b, logic last, logic [31:0] addr);
        int gap;
        gap = send_bursty ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {8'h00, addr, b};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(cmd, b, last, addr);
        items_sent++;
        if ($urandom_range(0, 60) == 0) send_bursty = !send_bursty;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(0, 3) != 0) ? hot_addrs[$urandom_range(0, 7)] : $urandom;
    endfunction

    // Frame builder: kind 0 good IPv4, 1 short, 2 other ethertype,
    // 3 IHL below five, 4 truncated transport header, 5 very long
    task automatic build_frame(int kind, ref logic [7:0] f[$]);
        int ihl, l4, len, sel;
        logic [7:0]  proto;
        logic [31:0] src;
        f.delete();
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        if (kind == 3) ihl = $urandom_range(0, 4);
        sel = $urandom_range(0, 9);
        proto = (sel < 4) ? PROTO_TCP : (sel < 8) ? PROTO_UDP : 8'($urandom);
        l4 = (proto == PROTO_TCP) ? 20 : (proto == PROTO_UDP) ? 8 : 0;
        src = pick_addr();
        len = 14 + 4 * (ihl < 5 ? 5 : ihl) + l4 + $urandom_range(0, 6);
        if (kind == 1) len = $urandom_range(1, 33);
        if (kind == 4) len = 14 + 4 * ihl + $urandom_range(0, l4 > 0 ? l4 - 1 : 0);
        if (kind == 5) len = 4100 + $urandom_range(0, 20);
        for (int i = 0; i < len; i++) f.push_back(8'($urandom));
        if (len > 13) begin
            f[12] = (kind == 2) ? 8'($urandom) : 8'h08;
            f[13] = (kind == 2) ? 8'($urandom) : 8'h00;
        end
        if (len > 14) f[14] = {4'($urandom_range(0, 15)), ihl[3:0]};
        if (len > 23) f[23] = proto;
        for (int i = 0; i < 4; i++)
            if (len > 26 + i) f[26 + i] = src[31 - 8 * i -: 8];
    endtask

    // Stream a frame, sometimes slipping table commands or reserved codes in
    task automatic send_frame(ref logic [7:0] f[$]);
        for (int i = 0; i < f.size(); i++) begin
            if ($urandom_range(0, 150) == 0)
                send($urandom_range(1, 2) == 1 ? CMD_INSERT : CMD_REMOVE, 8'($urandom),
                     1'($urandom), pick_addr());
            if ($urandom_range(0, 40) == 0)
                send(CMD_UNUSED, 8'($urandom), 1'($urandom), $urandom);
            send(CMD_BYTE, f[i], i == f.size() - 1, $urandom);
        end
    endtask

    initial begin
        logic [7:0] frame [$];
        int r;
        board = new();
        board.clear_parse();
        foreach (board.used[i]) board.used[i] = 1'b0;
        foreach (hot_addrs[i]) hot_addrs[i] = $urandom;
        hot_addrs[6] = 32'hFFFF_FFFF;
        hot_addrs[7] = 32'h0000_0000;
        items_sent    = 0;
        send_bursty   = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        idle_cycles   = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_BYTE;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table corner cases, reserved code, tiny and dropped frames
        send(CMD_REMOVE, 8'h00, 1'b0, 32'h0000_0000);
        send(CMD_INSERT, 8'hFF, 1'b1, hot_addrs[0]);
        send(CMD_INSERT, 8'h00, 1'b0, hot_addrs[0]);
        send(CMD_REMOVE, 8'h00, 1'b0, hot_addrs[0]);
        send(CMD_INSERT, 8'h00, 1'b0, hot_addrs[0]);
        send(CMD_INSERT, 8'h00, 1'b0, 32'hFFFF_FFFF);
        send(CMD_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send(CMD_BYTE, 8'hFF, 1'b1, 32'h0);
        build_frame(0, frame);
        for (int i = 0; i < 4; i++) frame[26 + i] = hot_addrs[0][31 - 8 * i -: 8];
        send_frame(frame);
        build_frame(3, frame);
        send_frame(frame);

        // Random: mostly well-formed frames, some broken ones and table traffic
        while (items_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send($urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE, 8'($urandom),
                     1'($urandom), pick_addr());
            else if (r < 10)
                send(CMD_UNUSED, 8'($urandom), 1'($urandom), $urandom);
            else begin
                r = $urandom_range(0, 99);
                build_frame(r < 65 ? 0 : r < 75 ? 1 : r < 82 ? 2 : r < 89 ? 3 : 4, frame);
                send_frame(frame);
            end
            if (items_sent > ITEM_GOAL / 2 && !hold_done) begin
                // Long receiver hold-off while a burst of commands queues up
                drain();
                hold_req  = 1'b1;
                hold_done = 1'b1;
                for (int i = 0; i < 5; i++)
                    send(CMD_INSERT, 8'($urandom), 1'b0, pick_addr());
                drain();
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** ipv4_source_blacklist_filter: PASSED **");
        else
            $display("** ipv4_source_blacklist_filter: FAILED **");
        $finish;
    end
endmodule

### ipv4_source_blacklist_filter.f
hdl/ibf_pkg.sv
hdl/ibf_table.sv
hdl/ibf_parser.sv
hdl/ibf_ctrl.sv
hdl/ipv4_source_blacklist_filter.sv
hdl/ibf_checker.sv
dv/tb_ipv4_source_blacklist_filter.sv
